// File: rtl/core/pffsa_pkg.sv
// Package for the page frame free stack allocator.
// Command kinds, status codes, field widths and the control state type.
// No dependencies.
package pffsa_pkg;

  // Field widths fixed by the stream and register formats
  localparam int ADDR_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 13;
  localparam int REG_W    = 32;

  // Command kinds carried in s_tuser
  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL_FREE = 3'd4;

  // Configuration register indexes
  localparam logic REG_KERNEL_END = 1'b0;
  localparam logic REG_MEMORY_TOP = 1'b1;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_INIT_CNT,
    S_ALLOC_RD,
    S_FREE_RD
  } state_t;

endpackage

// File: rtl/core/page_frame_free_stack_allocator.sv
// Page frame allocator: LIFO free stack plus per-page free bitmap in two RAMs.
// Depends on pffsa_pkg and pffsa_ram.
// Sequence per command: alloc and free read a RAM before the result is registered;
//   unused kinds and early errors answer from the execute state, init sweeps every entry.
// One command at a time; s_tready returns with m_tvalid, so the next command can be
//   taken while the previous result still waits for m_tready.
// Reset: synchronous; a sweep over every entry clears the bitmap before s_tready rises.
module page_frame_free_stack_allocator #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096   // power of two
) (
  input  logic                         clk,
  input  logic                         rst,
  // command stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pffsa_pkg::ADDR_W-1:0] s_tdata,   // [31:0] page_addr
  input  logic [pffsa_pkg::KIND_W-1:0] s_tuser,   // [1:0] kind
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [63:0]                  m_tdata,   // [2:0] status, [34:3] alloc_addr,
                                                  // [47:35] free_count,
                                                  // [60:48] total_count, rest zero
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [pffsa_pkg::REG_W-1:0]  pwdata,
  output logic [pffsa_pkg::REG_W-1:0]  prdata,
  output logic                         pready
);

  import pffsa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int LOG_PB = $clog2(PAGE_BYTES);

  // Configuration registers
  logic [REG_W-1:0] kernel_end;
  logic [REG_W-1:0] memory_top;

  // Control state
  state_t           state, state_next;
  logic             sweep_init;
  logic [IDX_W-1:0] sweep_idx;
  logic [CNT_W-1:0] stack_depth, stack_depth_next;
  logic [CNT_W-1:0] region_pages;
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W:0]  base_rnd;
  logic [KIND_W-1:0] cmd_kind;
  logic [ADDR_W-1:0] cmd_addr;
  logic [IDX_W-1:0] free_idx;

  // Result register
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_addr;
  logic [CNT_W-1:0]    out_free;
  logic [CNT_W-1:0]    out_total;

  // RAM ports
  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic             map_we, map_re;
  logic [IDX_W-1:0] map_waddr, map_raddr;
  logic             map_wdata, map_rdata;

  // Datapath helpers
  logic              in_xfer, out_slot, resp_load;
  logic [STATUS_W-1:0] resp_status;
  logic [ADDR_W-1:0] resp_addr;
  logic              sweep_last, sweep_hit;
  logic [ADDR_W-1:0] free_off, free_pg;
  logic              free_ok;
  logic [ADDR_W-1:0] top_off, top_pg;
  logic [CNT_W-1:0]  init_pages;
  logic              cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MEMORY_TOP) ? memory_top : kernel_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_end <= '0;
      memory_top <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_KERNEL_END) begin
        kernel_end <= pwdata;
      end else begin
        memory_top <= pwdata;
      end
    end
  end

  // Handshakes
  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_slot = !m_tvalid || m_tready;

  // Sweep helpers
  assign sweep_last = (sweep_idx == IDX_W'(MAX_PAGES - 1));
  assign sweep_hit  = (CNT_W'(sweep_idx) < region_pages);

  // Free address check
  assign free_off = cmd_addr - region_base;
  assign free_pg  = free_off >> LOG_PB;
  assign free_ok  = (cmd_addr != '0) && (cmd_addr >= region_base) &&
                    (free_off[LOG_PB-1:0] == '0) &&
                    (free_pg < ADDR_W'(region_pages));

  // Region size from the rounded base
  assign top_off = memory_top - base_rnd[ADDR_W-1:0];
  assign top_pg  = top_off >> LOG_PB;
  always_comb begin
    if (base_rnd[ADDR_W] || (memory_top < base_rnd[ADDR_W-1:0])) begin
      init_pages = '0;
    end else if (top_pg > ADDR_W'(MAX_PAGES)) begin
      init_pages = CNT_W'(MAX_PAGES);
    end else begin
      init_pages = top_pg[CNT_W-1:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM controls and result selection
  always_comb begin
    state_next       = state;
    stack_depth_next = stack_depth;
    stk_we    = 1'b0;
    stk_waddr = sweep_idx;
    stk_wdata = sweep_idx;
    stk_re    = 1'b0;
    stk_raddr = IDX_W'(stack_depth - CNT_W'(1));
    map_we    = 1'b0;
    map_waddr = sweep_idx;
    map_wdata = sweep_hit;
    map_re    = 1'b0;
    map_raddr = free_pg[IDX_W-1:0];
    resp_load   = 1'b0;
    resp_status = ST_OK;
    resp_addr   = '0;
    case (state)
      S_SWEEP: begin
        stk_we = 1'b1;
        map_we = 1'b1;
        if (sweep_last && (!sweep_init || out_slot)) begin
          state_next = S_IDLE;
          if (sweep_init) begin
            stack_depth_next = region_pages;
            resp_load        = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_kind)
          KIND_INIT: begin
            state_next = S_INIT_CNT;
          end
          KIND_ALLOC: begin
            if (stack_depth != '0) begin
              stk_re           = 1'b1;
              stack_depth_next = stack_depth - CNT_W'(1);
              state_next       = S_ALLOC_RD;
            end else if (out_slot) begin
              resp_load   = 1'b1;
              resp_status = ST_EMPTY;
              state_next  = S_IDLE;
            end
          end
          KIND_FREE: begin
            if (free_ok) begin
              map_re     = 1'b1;
              state_next = S_FREE_RD;
            end else if (out_slot) begin
              resp_load   = 1'b1;
              resp_status = (cmd_addr == '0) ? ST_NULL_FREE : ST_BAD_ADDR;
              state_next  = S_IDLE;
            end
          end
          default: begin
            if (out_slot) begin
              resp_load  = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_INIT_CNT: begin
        state_next = S_SWEEP;
      end
      S_ALLOC_RD: begin
        if (out_slot) begin
          map_we     = 1'b1;
          map_waddr  = stk_rdata;
          map_wdata  = 1'b0;
          resp_load  = 1'b1;
          resp_addr  = region_base + (ADDR_W'(stk_rdata) << LOG_PB);
          state_next = S_IDLE;
        end
      end
      S_FREE_RD: begin
        if (out_slot) begin
          resp_load  = 1'b1;
          state_next = S_IDLE;
          if (map_rdata || (stack_depth >= CNT_W'(MAX_PAGES))) begin
            resp_status = ST_DBL_FREE;
          end else begin
            stk_we           = 1'b1;
            stk_waddr        = stack_depth[IDX_W-1:0];
            stk_wdata        = free_idx;
            map_we           = 1'b1;
            map_waddr        = free_idx;
            map_wdata        = 1'b1;
            stack_depth_next = stack_depth + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_init   <= 1'b0;
      sweep_idx    <= '0;
      stack_depth  <= '0;
      region_pages <= '0;
      region_base  <= '0;
    end else begin
      stack_depth <= stack_depth_next;
      if (state == S_SWEEP && !sweep_last) begin
        sweep_idx <= sweep_idx + IDX_W'(1);
      end
      if (state == S_INIT_CNT) begin
        sweep_init   <= 1'b1;
        sweep_idx    <= '0;
        region_base  <= base_rnd[ADDR_W-1:0];
        region_pages <= init_pages;
      end
    end
  end

  // Command and working payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_kind <= s_tuser;
      cmd_addr <= s_tdata;
    end
    if (state == S_EXEC) begin
      base_rnd <= ({1'b0, kernel_end} + (ADDR_W+1)'(PAGE_BYTES - 1)) &
                  ~(ADDR_W+1)'(PAGE_BYTES - 1);
      free_idx <= free_pg[IDX_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (resp_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_status <= resp_status;
      out_addr   <= resp_addr;
      out_free   <= stack_depth_next;
      out_total  <= region_pages;
    end
  end

  assign m_tdata = {3'b000,
                    COUNT_W'(out_total),
                    COUNT_W'(out_free),
                    out_addr,
                    out_status};

  // Free stack of page indexes
  pffsa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PAGES)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  // Free bitmap, one bit per page
  pffsa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PAGES)
  ) u_map (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (map_waddr),
    .wr_data (map_wdata),
    .rd_en   (map_re),
    .rd_addr (map_raddr),
    .rd_data (map_rdata)
  );

  // Checks; during a sweep the depth still holds the previous region's count
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_SWEEP) |-> (stack_depth <= region_pages))
    else $error("stack depth exceeds managed page count");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_EXEC))
    else $error("accepted command not executed");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE_RD && out_slot && !map_rdata &&
     stack_depth < CNT_W'(MAX_PAGES))
    |=> (stack_depth == $past(stack_depth) + CNT_W'(1)))
    else $error("free push did not grow the stack");

endmodule

// File: rtl/core/pffsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the free stack and the free bitmap. No dependencies.
module pffsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: test/page_frame_free_stack_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the page frame free stack allocator.
// Drives commands, the APB registers and result backpressure; predicts every result.
// Depends on pffsa_pkg and page_frame_free_stack_allocator.
module page_frame_free_stack_allocator_tb;
  import pffsa_pkg::*;

  localparam int MAX_PAGES      = 4096;
  localparam int PAGE_BYTES     = 4096;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 920;

  // One result transfer, fields as carried in m_tdata
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  total_count;
  } page_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ADDR_W-1:0]   s_tdata  = '0;
  logic [KIND_W-1:0]   s_tuser  = KIND_INIT;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [63:0]         m_tdata;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [2:0]          paddr    = '0;
  logic [REG_W-1:0]    pwdata   = '0;
  logic [REG_W-1:0]    prdata;
  logic                pready;

  page_frame_free_stack_allocator #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Allocator state as the testbench sees it
  logic [31:0] kend_reg = '0;
  logic [31:0] mtop_reg = '0;
  logic [11:0] page_stack [MAX_PAGES];
  bit          page_is_free [MAX_PAGES];
  int unsigned free_depth   = 0;
  logic [31:0] region_start = '0;
  int unsigned region_len   = 0;

  page_result_t pending_results [$];
  page_result_t got_res, want_res;

  int  errors          = 0;
  int  results_checked = 0;
  int  status_seen [8];
  int  kind_count [4];
  bit  idle_en         = 1'b1;
  bit  tx_open         = 1'b0;
  int  hold_reqs       = 0;
  int  hold_done       = 0;
  int  hold_left       = 0;
  int  stall_left      = 0;
  int  quiet_cycles    = 0;

  // Expected result of one command; updates the tracked state
  function automatic page_result_t predict_page_result(logic [KIND_W-1:0] kind,
                                                       logic [ADDR_W-1:0] addr);
    page_result_t    r;
    logic [32:0]     rounded;
    logic [31:0]     off;
    longint unsigned n;
    int unsigned     idx;
    int              i;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_INIT: begin
        rounded = {1'b0, kend_reg} + 33'(PAGE_BYTES - 1);
        rounded = rounded - (rounded % PAGE_BYTES);
        region_start = rounded[31:0];
        n = 0;
        if (!rounded[32] && mtop_reg >= rounded[31:0])
          n = (mtop_reg - rounded[31:0]) / PAGE_BYTES;
        if (n > MAX_PAGES) n = MAX_PAGES;
        region_len = n;
        for (i = 0; i < MAX_PAGES; i++) begin
          page_is_free[i] = (i < region_len);
          if (i < region_len) page_stack[i] = 12'(i);
        end
        free_depth = region_len;
      end
      KIND_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_depth--;
          idx = page_stack[free_depth];
          page_is_free[idx] = 1'b0;
          r.alloc_addr = region_start + idx * PAGE_BYTES;
        end
      end
      KIND_FREE: begin
        off = addr - region_start;
        idx = off / PAGE_BYTES;
        if (addr == 0) begin
          r.status = ST_NULL_FREE;
        end else if (addr < region_start || off % PAGE_BYTES != 0 || idx >= region_len) begin
          r.status = ST_BAD_ADDR;
        end else if (page_is_free[idx] || free_depth >= MAX_PAGES) begin
          r.status = ST_DBL_FREE;
        end else begin
          page_stack[free_depth] = 12'(idx);
          free_depth++;
          page_is_free[idx] = 1'b1;
        end
      end
      default: ;
    endcase
    r.free_count  = free_depth;
    r.total_count = region_len;
    return r;
  endfunction

  // Drop tvalid if the last transfer left it high
  task automatic bus_quiet();
    if (tx_open) begin
      s_tvalid <= 1'b0;
      tx_open = 1'b0;
    end
  endtask

  // Offer one command and wait for its transfer
  task automatic send_cmd(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= addr;
    tx_open = 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_results.push_back(predict_page_result(kind, addr));
    kind_count[kind]++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      bus_quiet();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    bus_quiet();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write followed by a read back
  task automatic reg_write(logic reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_KERNEL_END) kend_reg = value;
    else mtop_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      errors++;
      $display("%0t: register %0d read back, expected %h, actual %h",
               $time, reg_idx, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_region(logic [31:0] kend, logic [31:0] mtop);
    wait_drain();
    reg_write(REG_KERNEL_END, kend);
    reg_write(REG_MEMORY_TOP, mtop);
  endtask

  // One command from the random mix; frees mostly target pages handed out
  task automatic send_random_cmd();
    int          r;
    int          tries;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_cmd(KIND_ALLOC, $urandom());
    end else if (r < 85) begin
      idx = 0;
      for (tries = 0; tries < 8 && region_len != 0; tries++) begin
        idx = $urandom_range(0, region_len - 1);
        if (!page_is_free[idx]) break;
      end
      send_cmd(KIND_FREE, region_start + idx * PAGE_BYTES);
    end else if (r < 88) begin
      send_cmd(KIND_FREE, region_start + region_len * PAGE_BYTES);
    end else if (r < 91) begin
      send_cmd(KIND_FREE, $urandom());
    end else if (r < 94) begin
      send_cmd(KIND_FREE, region_start + $urandom_range(1, PAGE_BYTES - 1));
    end else if (r < 96) begin
      send_cmd(KIND_FREE, '0);
    end else if (r < 98) begin
      send_cmd(KIND_UNUSED, $urandom());
    end else begin
      send_cmd(KIND_INIT, $urandom());
    end
  endtask

  // Commands before any init: empty stack, nothing managed
  task automatic test_idle_commands();
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_FREE, 32'h0000_1000);
    send_cmd(KIND_FREE, '0);
    send_cmd(KIND_UNUSED, 32'hFFFF_FFFF);
  endtask

  // Three pages at address zero: pop order, null, bad and double frees, empty
  task automatic test_small_region();
    set_region(32'h0, 3 * PAGE_BYTES + 32'h800);
    send_cmd(KIND_INIT, '0);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_FREE, '0);
    send_cmd(KIND_FREE, 2 * PAGE_BYTES);
    send_cmd(KIND_FREE, 2 * PAGE_BYTES);
    send_cmd(KIND_FREE, PAGE_BYTES + 4);
    send_cmd(KIND_FREE, 3 * PAGE_BYTES);
    send_cmd(KIND_FREE, 32'hFFFF_FFFF);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_ALLOC, '0);
  endtask

  // Rounding overflow, top below base, and a region clamped to the stack size
  task automatic test_region_edges();
    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(KIND_INIT, '0);
    send_cmd(KIND_ALLOC, '0);
    set_region(32'h0000_5000, 32'h0);
    send_cmd(KIND_INIT, '0);
    send_cmd(KIND_FREE, 32'h0000_4000);
    set_region(32'h0, 32'hFFFF_FFFF);
    send_cmd(KIND_INIT, '0);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_FREE, (MAX_PAGES - 1) * PAGE_BYTES);
  endtask

  // Receiver stops for a long stretch while commands keep coming
  task automatic test_backpressure();
    int i;
    set_region(32'h0010_0000, 32'h0010_0000 + 6 * PAGE_BYTES);
    send_cmd(KIND_INIT, '0);
    wait_drain();
    hold_reqs++;
    for (i = 0; i < 24; i++) send_random_cmd();
  endtask

  // Phases of random regions, each an init followed by mixed traffic
  task automatic test_random_traffic();
    int          sent;
    int          phase_len;
    int          r;
    int          i;
    logic [31:0] kend;
    logic [31:0] mtop;
    logic [32:0] top_calc;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent > RANDOM_ITEMS - 150) idle_en = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        kend = $urandom_range(0, 4 * PAGE_BYTES);
        mtop = 32'hFFFF_FFFF;
        phase_len = 150;
      end else if (r < 12) begin
        kend = 32'hFFFF_FFFF - $urandom_range(0, PAGE_BYTES - 2);
        mtop = $urandom();
        phase_len = 10;
      end else if (r < 16) begin
        kend = $urandom_range(PAGE_BYTES, 32'h7FFF_FFFF);
        mtop = kend - $urandom_range(1, PAGE_BYTES);
        phase_len = 10;
      end else begin
        kend = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
        top_calc = {1'b0, kend} + 33'($urandom_range(0, 24) * PAGE_BYTES)
                   + 33'($urandom_range(0, PAGE_BYTES - 1));
        mtop = top_calc[32] ? 32'hFFFF_FFFF : top_calc[31:0];
        phase_len = $urandom_range(15, 50);
      end
      // Keep the total near the planned item count
      if (phase_len > RANDOM_ITEMS - sent - 1) phase_len = RANDOM_ITEMS - sent - 1;
      set_region(kend, mtop);
      send_cmd(KIND_INIT, $urandom());
      for (i = 0; i < phase_len; i++) send_random_cmd();
      sent += phase_len + 1;
    end
  endtask

  // Result receiver: random stalls plus the long hold on request
  always @(posedge clk) begin
    if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got_res.status      = m_tdata[2:0];
      got_res.alloc_addr  = m_tdata[34:3];
      got_res.free_count  = m_tdata[47:35];
      got_res.total_count = m_tdata[60:48];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata %h", $time, m_tdata);
      end else begin
        want_res = pending_results.pop_front();
        results_checked++;
        status_seen[want_res.status]++;
        check_field("status", want_res.status, got_res.status);
        check_field("alloc_addr", want_res.alloc_addr, got_res.alloc_addr);
        check_field("free_count", want_res.free_count, got_res.free_count);
        check_field("total_count", want_res.total_count, got_res.total_count);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_small_region();
    test_region_edges();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d commands: %0d init, %0d alloc, %0d free, %0d unused; %0d results checked.",
             kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3], kind_count[0],
             kind_count[1], kind_count[2], kind_count[3], results_checked);
    $display("Statuses seen: ok %0d, empty %0d, bad address %0d, double free %0d, null %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BAD_ADDR],
             status_seen[ST_DBL_FREE], status_seen[ST_NULL_FREE]);
    if (errors == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pffsa_pkg.sv
rtl/core/pffsa_ram.sv
rtl/core/page_frame_free_stack_allocator.sv
test/page_frame_free_stack_allocator_tb.sv
